// ===== rtl/offset_table_partition_lookup_macros.svh =====
// Assertion macros used by the offset table lookup core.
// The macros expect clk and rst_n to be visible in the including scope.
`ifndef OFFSET_TABLE_PARTITION_LOOKUP_MACROS_SVH
`define OFFSET_TABLE_PARTITION_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTPL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OTPL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/otpl_pkg.sv =====
// Package for the offset table lookup: field widths, mode and register codes,
// and the item and result structures. No dependencies.
`timescale 1ns / 1ps

package otpl_pkg;

    localparam int SLOT_W    = 10;
    localparam int VAL_W     = 32;
    localparam int PART_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_WRITE     = 2'd0;
    localparam mode_t MODE_LOCATE    = 2'd1;
    localparam mode_t MODE_TRANSLATE = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PARTITION_COUNT = 1'b0;
    localparam cfg_idx_t REG_TOTAL_OBJECTS   = 1'b1;

    typedef struct packed {
        mode_t             mode;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic [PART_W-1:0] partition;
        logic [VAL_W-1:0]  local_index;
        logic [VAL_W-1:0]  global_index;
        logic [VAL_W-1:0]  partition_size;
        logic              below_first;
    } res_t;

endpackage

// ===== rtl/otpl_item_if.sv =====
// Valid/ready channel interfaces for lookup items and lookup results.
// Depends on otpl_pkg for the field widths.
`timescale 1ns / 1ps

interface otpl_item_if import otpl_pkg::*; ();
    logic              valid;
    logic              ready;
    mode_t             mode;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output mode, output slot, output value, input ready);
    modport sink   (input valid, input mode, input slot, input value, output ready);
endinterface

interface otpl_result_if import otpl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PART_W-1:0] partition;
    logic [VAL_W-1:0]  local_index;
    logic [VAL_W-1:0]  global_index;
    logic [VAL_W-1:0]  partition_size;
    logic              below_first;

    modport source (output valid, output partition, output local_index,
                    output global_index, output partition_size, output below_first,
                    input ready);
    modport sink   (input valid, input partition, input local_index,
                    input global_index, input partition_size, input below_first,
                    output ready);
endinterface

// ===== rtl/otpl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module otpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/otpl_core.sv =====
// Sequencer for the offset table: stores offsets, runs the binary search over
// the table RAM and forms the result. Depends on otpl_pkg and the macro header.
`timescale 1ns / 1ps
`include "offset_table_partition_lookup_macros.svh"

module otpl_core import otpl_pkg::*; #(
    parameter int MAX_PARTS = 1024,
    parameter int AW        = $clog2(MAX_PARTS),
    parameter int CW        = $clog2(MAX_PARTS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    input  logic [CW-1:0]    eff_count,
    input  logic [VAL_W-1:0] total_objects,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [VAL_W-1:0] ram_wdata,
    output logic [AW-1:0]    ram_raddr,
    input  logic [VAL_W-1:0] ram_rdata
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_BASE   = 5'b00100,
        S_SIZE   = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    mode_t            mode_reg, mode_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    len_reg, len_next;
    logic [CW-1:0]    part_reg, part_next;
    logic [VAL_W-1:0] base_reg, base_next;
    logic [VAL_W-1:0] start0_reg, start0_next;
    logic             last_reg, last_next;
    res_t             res_reg, res_next;

    logic [CW-1:0]    half;
    logic [CW-1:0]    lo_n;
    logic [CW-1:0]    len_n;
    logic [CW-1:0]    probe;
    logic [CW-1:0]    slot_inc;
    logic [VAL_W-1:0] next_start;
    logic             le;

    assign half       = len_reg >> 1;
    assign le         = (ram_rdata <= value_reg);
    assign slot_inc   = CW'(slot_reg) + CW'(1);
    assign next_start = last_reg ? (total_objects + start0_reg) : ram_rdata;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        slot_next   = slot_reg;
        value_next  = value_reg;
        lo_next     = lo_reg;
        len_next    = len_reg;
        part_next   = part_reg;
        base_next   = base_reg;
        start0_next = start0_reg;
        last_next   = last_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_waddr   = AW'(item.slot);
        ram_wdata   = item.value;
        ram_raddr   = '0;
        lo_n        = lo_reg;
        len_n       = half;
        probe       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    mode_next  = item.mode;
                    slot_next  = AW'(item.slot);
                    value_next = item.value;
                    res_next   = '0;
                    case (item.mode)
                        MODE_WRITE:
                        begin
                            if (32'(item.slot) < 32'(MAX_PARTS))
                            begin
                                ram_we = 1'b1;
                                if (item.slot == '0)
                                begin
                                    start0_next = item.value;
                                end
                            end
                            state_next = S_OUT;
                        end
                        MODE_LOCATE:
                        begin
                            lo_next    = '0;
                            len_next   = eff_count;
                            probe      = eff_count >> 1;
                            ram_raddr  = probe[AW-1:0];
                            state_next = S_SEARCH;
                        end
                        MODE_TRANSLATE:
                        begin
                            if (32'(item.slot) < 32'(eff_count))
                            begin
                                ram_raddr  = AW'(item.slot);
                                part_next  = CW'(item.slot);
                                state_next = S_BASE;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (le)
                begin
                    lo_n      = lo_reg + half + CW'(1);
                    len_n     = len_reg - half - CW'(1);
                    base_next = ram_rdata;
                end
                lo_next  = lo_n;
                len_next = len_n;
                if (len_n != '0)
                begin
                    probe     = lo_n + (len_n >> 1);
                    ram_raddr = probe[AW-1:0];
                end
                else if (lo_n == '0)
                begin
                    res_next.below_first = 1'b1;
                    state_next           = S_OUT;
                end
                else
                begin
                    part_next  = lo_n - CW'(1);
                    last_next  = (lo_n == eff_count);
                    ram_raddr  = lo_n[AW-1:0];
                    state_next = S_SIZE;
                end
            end
            S_BASE:
            begin
                base_next  = ram_rdata;
                last_next  = (slot_inc == eff_count);
                ram_raddr  = slot_inc[AW-1:0];
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                res_next.partition      = PART_W'(part_reg);
                res_next.partition_size = next_start - base_reg;
                if (mode_reg == MODE_LOCATE)
                begin
                    res_next.local_index = value_reg - base_reg;
                end
                else
                begin
                    res_next.global_index = value_reg + base_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        slot_reg   <= slot_next;
        value_reg  <= value_next;
        lo_reg     <= lo_next;
        len_reg    <= len_next;
        part_reg   <= part_next;
        base_reg   <= base_next;
        start0_reg <= start0_next;
        last_reg   <= last_next;
        res_reg    <= res_next;
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res        = res_reg;

    `OTPL_ASSERT_NXT(a_accept_leaves_idle, item_valid && item_ready, state_reg != S_IDLE,
        "core stayed idle after an item transfer")
    `OTPL_ASSERT_IMP(a_write_only_idle, ram_we, state_reg == S_IDLE,
        "table write outside the idle state")
    `OTPL_ASSERT_IMP(a_search_len_nonzero, state_reg == S_SEARCH, len_reg != '0,
        "search running with an empty range")
    `OTPL_ASSERT_IMP(a_search_in_range, state_reg == S_SEARCH,
        (32'(lo_reg) + 32'(len_reg)) <= 32'(eff_count),
        "search range runs past the partition count")
    `OTPL_ASSERT_IMP(a_below_first_zero, res_valid && res.below_first,
        res.partition == '0 && res.partition_size == '0 && res.local_index == '0,
        "below-first result carries nonzero fields")

endmodule

// ===== rtl/offset_table_partition_lookup.sv =====
// Offset table partition lookup: a write, an unknown mode or a rejected translate goes
// straight to the result; a translate reads the base offset and then the next offset; a
// locate runs a binary search over the table, one table RAM read per step.
// One item is in work at a time, so no new item is taken until the last result has left
// the core; the output register lets the next item start while a result waits.
// Reset clears control state, sets partition_count to 1 and total_objects to 0.
`timescale 1ns / 1ps

module offset_table_partition_lookup import otpl_pkg::*; #(
    parameter int MAX_PARTS = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    otpl_item_if.sink            item,
    otpl_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);

    logic [COUNT_W-1:0] pcount_reg;
    logic [VAL_W-1:0]   total_reg;
    logic [CW-1:0]      eff_count;

    logic               out_valid_reg, out_valid_next;
    res_t               out_data_reg, out_data_next;

    item_t              core_item;
    logic               core_ready;
    logic               res_valid;
    logic               res_ready;
    res_t               res;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= COUNT_W'(1);
            total_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PARTITION_COUNT: pcount_reg <= cfg_wdata[COUNT_W-1:0];
                REG_TOTAL_OBJECTS:   total_reg  <= cfg_wdata[VAL_W-1:0];
                default:             total_reg  <= total_reg;
            endcase
        end
    end

    always_comb
    begin
        if (pcount_reg == '0)
        begin
            eff_count = CW'(1);
        end
        else if (32'(pcount_reg) > 32'(MAX_PARTS))
        begin
            eff_count = CW'(MAX_PARTS);
        end
        else
        begin
            eff_count = CW'(pcount_reg);
        end
    end

    assign core_item.mode  = item.mode;
    assign core_item.slot  = item.slot;
    assign core_item.value = item.value;
    assign item.ready      = core_ready;

    otpl_core #(
        .MAX_PARTS (MAX_PARTS),
        .AW        (AW),
        .CW        (CW)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item.valid),
        .item_ready    (core_ready),
        .item          (core_item),
        .eff_count     (eff_count),
        .total_objects (total_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    otpl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_PARTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.partition      = out_data_reg.partition;
    assign result.local_index    = out_data_reg.local_index;
    assign result.global_index   = out_data_reg.global_index;
    assign result.partition_size = out_data_reg.partition_size;
    assign result.below_first    = out_data_reg.below_first;

endmodule
